>>> design/gas_pkg.sv
// Shared constants and control structures for the global alignment score block.
package gas_pkg;

    localparam int MAX_LEN_DEF    = 64;
    localparam int SCORE_BITS_DEF = 10;

    localparam int SYM_W      = 8;
    localparam int MATCH_W    = 4;
    localparam int MISMATCH_W = 5;
    localparam int OUT_SCORE_W = 10;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [MATCH_W-1:0]           MATCH_RST    = 4'd3;
    localparam logic signed [MISMATCH_W-1:0] MISMATCH_RST = -5'sd1;

    typedef enum logic {
        REG_MATCH    = 1'b0,
        REG_MISMATCH = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_FEED = 1'b1
    } t_mode;

    typedef struct packed {
        logic load;
        logic start;
        logic col_end;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic overflow;
    } t_status;

endpackage

>>> design/gas_datapath.sv
// Datapath: sequence and column memories, cell update unit and sequence state.
module gas_datapath
    import gas_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [SYM_W-1:0]             i_symbol,
    input  logic                         i_last,
    input  logic [MATCH_W-1:0]           i_match,
    input  logic signed [MISMATCH_W-1:0] i_mismatch,
    output t_status                      o_status,
    output logic [SCORE_BITS-1:0]        o_score
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int SUM_W = SCORE_BITS + 2;
    localparam logic signed [SUM_W-1:0] SAT = SUM_W'((1 << SCORE_BITS) - 1);

    logic [SYM_W-1:0]      r_seq_mem [MAX_LEN];
    logic [SCORE_BITS-1:0] r_col_mem [MAX_LEN];

    logic [LEN_W-1:0]      r_len;
    logic                  r_ovf;
    logic                  r_loaded;
    logic                  r_fresh;
    logic [SYM_W-1:0]      r_sym;
    logic [LEN_W-1:0]      r_rd;
    logic                  r_issue;
    logic                  r_cmp_v;
    logic                  r_cmp_last;
    logic [IDX_W-1:0]      r_cmp_addr;
    logic [SCORE_BITS-1:0] r_diag;
    logic [SCORE_BITS-1:0] r_left;
    logic                  r_fin;
    logic [SYM_W-1:0]      r_seq_q;
    logic [SCORE_BITS-1:0] r_col_q;

    logic                         seq_we;
    logic [IDX_W-1:0]             seq_waddr;
    logic [IDX_W-1:0]             rd_addr;
    logic [SCORE_BITS-1:0]        above;
    logic signed [SUM_W-1:0]      add_val;
    logic signed [SUM_W-1:0]      diag_sum;
    logic signed [SUM_W-1:0]      best;
    logic [SCORE_BITS-1:0]        n_cell;

    assign rd_addr = IDX_W'(r_rd - LEN_W'(1));

    always_comb begin
        seq_we    = 1'b0;
        seq_waddr = '0;
        if (i_cmd.load) begin
            if (r_loaded) begin
                seq_we    = 1'b1;
                seq_waddr = '0;
            end else if (r_len < LEN_W'(MAX_LEN)) begin
                seq_we    = 1'b1;
                seq_waddr = IDX_W'(r_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            r_seq_mem[seq_waddr] <= i_symbol;
        end
        r_seq_q <= r_seq_mem[rd_addr];
    end

    always_comb begin
        above    = r_fresh ? '0 : r_col_q;
        add_val  = (r_seq_q == r_sym) ? $signed({{(SUM_W-MATCH_W){1'b0}}, i_match})
                                      : SUM_W'(i_mismatch);
        diag_sum = $signed({2'b00, r_diag}) + add_val;
        best     = $signed({2'b00, above});
        if (diag_sum > best) begin
            best = diag_sum;
        end
        if ($signed({2'b00, r_left}) > best) begin
            best = $signed({2'b00, r_left});
        end
        if (best > SAT) begin
            best = SAT;
        end
        n_cell = best[SCORE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_v) begin
            r_col_mem[r_cmp_addr] <= n_cell;
        end
        r_col_q <= r_col_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_loaded <= 1'b0;
            r_fresh  <= 1'b1;
            r_issue  <= 1'b0;
            r_cmp_v  <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fresh  <= 1'b1;
                r_loaded <= i_last;
                if (r_loaded) begin
                    r_len <= LEN_W'(1);
                    r_ovf <= 1'b0;
                end else if (r_len < LEN_W'(MAX_LEN)) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_loaded <= 1'b1;
                r_issue  <= (r_len != '0);
            end else if (r_issue && (r_rd == r_len)) begin
                r_issue <= 1'b0;
            end
            if (i_cmd.col_end) begin
                r_fresh <= i_cmd.clear;
            end
            r_cmp_v <= r_issue;
            r_fin   <= (i_cmd.start && (r_len == '0)) || (r_cmp_v && r_cmp_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sym  <= i_symbol;
            r_rd   <= LEN_W'(1);
            r_left <= '0;
            r_diag <= '0;
        end else begin
            if (r_issue) begin
                r_rd <= r_rd + LEN_W'(1);
            end
            if (r_cmp_v) begin
                r_left <= n_cell;
                r_diag <= above;
            end
        end
        r_cmp_last <= (r_rd == r_len);
        r_cmp_addr <= rd_addr;
    end

    assign o_status.done     = r_fin;
    assign o_status.overflow = r_ovf;
    assign o_score           = r_left;

endmodule

>>> design/gas_ctrl.sv
// Controller: input and output handshakes, item sequencing and result register.
module gas_ctrl
    import gas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_mode,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_cmd                   o_cmd,
    input  t_status                i_status,
    input  logic [OUT_SCORE_W-1:0] i_score,
    output logic [OUT_SCORE_W-1:0] o_score,
    output logic                   o_overflow
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_last;
    logic   r_out_valid, n_out_valid;
    logic   [OUT_SCORE_W-1:0] r_score;
    logic   r_overflow;
    logic   accept;
    logic   capture;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        capture       = 1'b0;
        o_cmd.load    = accept && (i_mode == MODE_LOAD);
        o_cmd.start   = accept && (i_mode == MODE_FEED);
        o_cmd.col_end = 1'b0;
        o_cmd.clear   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.done) begin
                    o_cmd.col_end = 1'b1;
                    o_cmd.clear   = r_last;
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        capture = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    capture = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = capture || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.start) begin
            r_last <= i_last;
        end
        if (capture) begin
            r_score    <= i_score;
            r_overflow <= i_status.overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_overflow  = r_overflow;

endmodule

>>> design/global_alignment_score_top.sv
// Top level of the global alignment score block with its register port.
//
// Input items arrive on the i_in_valid / o_in_ready channel. Mode 0 loads one
// symbol of the first sequence and leaves the block ready for the next item;
// i_last closes the sequence. Mode 1 feeds one symbol of the second sequence
// and updates one column of the score matrix, one cell per cycle through the
// column memory; the block takes no new item until that column is finished.
// A mode 1 item with i_last set produces one result transfer on the
// o_out_valid / i_out_ready channel, carrying the bottom-right score and the
// truncation flag; the output register is loaded once the last column is
// finished and any earlier result has been transferred.
// The result waits in an output register while the receiver stalls, and new
// items are still taken; only a second result is held back until the first
// has been transferred. The user must see that match and mismatch scores are
// written over the APB port only while the block is idle; the block does not
// enforce it. Synchronous reset empties the first sequence, makes the stored
// score column read as zero and restores the scores to three and minus one.
module global_alignment_score_top
    import gas_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_mode,
    input  logic [SYM_W-1:0]       i_symbol,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_SCORE_W-1:0] o_score,
    output logic                   o_overflow
);

    logic [MATCH_W-1:0]           r_match;
    logic signed [MISMATCH_W-1:0] r_mismatch;
    logic                         reg_wr;
    t_reg_idx                     reg_idx;
    t_cmd                         cmd;
    t_status                      status;
    logic [SCORE_BITS-1:0]        dp_score;
    logic [OUT_SCORE_W-1:0]       cell_score;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= MATCH_RST;
            r_mismatch <= MISMATCH_RST;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_MATCH:    r_match    <= pwdata[MATCH_W-1:0];
                REG_MISMATCH: r_mismatch <= $signed(pwdata[MISMATCH_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MATCH:    prdata = APB_DATA_W'(r_match);
            REG_MISMATCH: prdata = APB_DATA_W'(r_mismatch);
            default:      prdata = '0;
        endcase
    end

    assign cell_score = OUT_SCORE_W'(dp_score);

    gas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status),
        .i_score     (cell_score),
        .o_score     (o_score),
        .o_overflow  (o_overflow)
    );

    gas_datapath #(
        .MAX_LEN    (MAX_LEN),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_symbol   (i_symbol),
        .i_last     (i_last),
        .i_match    (r_match),
        .i_mismatch (r_mismatch),
        .o_status   (status),
        .o_score    (dp_score)
    );

endmodule
